// File: rtl/bdm_pkg.sv
package bdm_pkg;

  // One raw column: top sample in the lowest bits.
  typedef struct packed {
    logic [7:0] bottom;
    logic [7:0] middle;
    logic [7:0] top;
  } col_t;

  // RGB pixel: red in the lowest bits.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Neighbourhood and phase handed to the interpolator.
  typedef struct packed {
    col_t       lc;
    col_t       cc;
    col_t       rc;
    logic       parity;
    logic [1:0] mode;
  } win_t;

endpackage

// File: rtl/bdm_pixel.sv
module bdm_pixel (
  input  bdm_pkg::win_t win_i,
  output bdm_pkg::rgb_t rgb_o
);
  import bdm_pkg::*;

  logic       green_site;
  logic       red_row;
  logic [8:0] h_sum;
  logic [8:0] v_sum;
  logic [9:0] diag_sum;
  logic [9:0] cross_sum;
  logic [7:0] h_avg;
  logic [7:0] v_avg;
  logic [7:0] diag_avg;
  logic [7:0] cross_avg;

  assign green_site = (win_i.parity ^ win_i.mode[1]) == 1'b0;
  assign red_row    = win_i.mode[0];

  assign h_sum     = {1'b0, win_i.lc.middle} + {1'b0, win_i.rc.middle};
  assign v_sum     = {1'b0, win_i.cc.top} + {1'b0, win_i.cc.bottom};
  assign diag_sum  = {2'b00, win_i.lc.top} + {2'b00, win_i.rc.top}
                   + {2'b00, win_i.lc.bottom} + {2'b00, win_i.rc.bottom};
  assign cross_sum = {2'b00, win_i.cc.top} + {2'b00, win_i.lc.middle}
                   + {2'b00, win_i.rc.middle} + {2'b00, win_i.cc.bottom};

  assign h_avg     = h_sum[8:1];
  assign v_avg     = v_sum[8:1];
  assign diag_avg  = diag_sum[9:2];
  assign cross_avg = cross_sum[9:2];

  always_comb begin
    if (green_site) begin
      rgb_o.green = win_i.cc.middle;
      rgb_o.red   = red_row ? h_avg : v_avg;
      rgb_o.blue  = red_row ? v_avg : h_avg;
    end else begin
      rgb_o.green = cross_avg;
      rgb_o.red   = red_row ? win_i.cc.middle : diag_avg;
      rgb_o.blue  = red_row ? diag_avg : win_i.cc.middle;
    end
  end

endmodule

// File: rtl/bayer_demosaic_3x3_bilinear_top.sv
// Latency: 2 register stages; the pixel that a column causes is held in the input register
// stage and then loaded into the output register once the output can take it.
// Throughput: one column per cycle while the output is not stalled; a column marked tlast after
// the first of its row holds the input stage while it emits the pixel behind it and the final pixel in turn.
// Reset (rst_ni low, asynchronous): pipeline empty, column history and the
// column count and pixel parity cleared.
module bayer_demosaic_3x3_bilinear_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // top_pixel, middle_pixel, bottom_pixel
  input  logic [1:0]  s_axis_tuser_i,   // mode
  input  logic        s_axis_tlast_i,   // last_in_row
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // red, green, blue
  output logic        m_axis_tuser_o,   // last_of_run
  output logic        m_axis_tlast_o    // row_end
);
  import bdm_pkg::*;

  // Column history
  col_t       older_q, prev_q;
  logic [1:0] seen_q, seen_d;
  logic       parity_q, parity_d;

  // Input register stage
  logic       s1_valid_q;
  col_t       s1_left_q, s1_prev_q, s1_cur_q;
  logic       s1_parity_q;
  logic [1:0] s1_mode_q;
  logic       s1_last_q;
  logic       s1_seen0_q;
  logic       phase_q, phase_d;

  // Result register
  logic       out_valid_q;
  rgb_t       out_rgb_q;
  logic       out_row_end_q;
  logic       out_lor_q;

  logic       s_accept;
  logic       out_ready;
  logic       s1_emit;
  logic       s1_two;
  logic       s1_fire;
  logic       s1_done;
  col_t       in_col;
  win_t       win;
  rgb_t       rgb;
  logic       pix_row_end;
  logic       pix_lor;

  assign in_col    = col_t'(s_axis_tdata_i);
  assign out_ready = !out_valid_q || m_axis_tready_i;

  // A first column that is not the last one gives no pixel.
  assign s1_emit = s1_valid_q && !(s1_seen0_q && !s1_last_q);
  assign s1_two  = s1_last_q && !s1_seen0_q;
  assign s1_fire = s1_emit && out_ready;
  assign s1_done = s1_valid_q && (!s1_emit || (out_ready && (!s1_two || phase_q)));

  assign s_axis_tready_o = !s1_valid_q || s1_done;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    seen_d   = seen_q;
    parity_d = parity_q;
    if (s_axis_tlast_i) begin
      seen_d   = 2'd0;
      parity_d = 1'b0;
    end else begin
      if (seen_q != 2'd2) seen_d = seen_q + 2'd1;
      if (seen_q != 2'd0) parity_d = ~parity_q;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (s1_done) phase_d = 1'b0;
    else if (s1_fire && s1_two) phase_d = 1'b1;
  end

  // Window for the pixel leaving the input stage this cycle
  always_comb begin
    win.mode = s1_mode_q;
    if (s1_seen0_q) begin
      win.lc      = s1_cur_q;
      win.cc      = s1_cur_q;
      win.rc      = s1_cur_q;
      win.parity  = 1'b0;
      pix_row_end = 1'b1;
      pix_lor     = 1'b1;
    end else if (!phase_q) begin
      win.lc      = s1_left_q;
      win.cc      = s1_prev_q;
      win.rc      = s1_cur_q;
      win.parity  = s1_parity_q;
      pix_row_end = 1'b0;
      pix_lor     = !s1_last_q;
    end else begin
      // final pixel of the row, right edge folded
      win.lc      = s1_prev_q;
      win.cc      = s1_cur_q;
      win.rc      = s1_prev_q;
      win.parity  = ~s1_parity_q;
      pix_row_end = 1'b1;
      pix_lor     = 1'b1;
    end
  end

  bdm_pixel u_pixel (
    .win_i (win),
    .rgb_o (rgb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q     <= '0;
      prev_q      <= '0;
      seen_q      <= 2'd0;
      parity_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (s_accept) begin
        older_q    <= prev_q;
        prev_q     <= in_col;
        seen_q     <= seen_d;
        parity_q   <= parity_d;
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      // second column of a row folds its left edge onto itself
      s1_left_q   <= (seen_q == 2'd1) ? in_col : older_q;
      s1_prev_q   <= prev_q;
      s1_cur_q    <= in_col;
      s1_parity_q <= parity_q;
      s1_mode_q   <= s_axis_tuser_i;
      s1_last_q   <= s_axis_tlast_i;
      s1_seen0_q  <= (seen_q == 2'd0);
    end
    if (s1_fire) begin
      out_rgb_q     <= rgb;
      out_row_end_q <= pix_row_end;
      out_lor_q     <= pix_lor;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rgb_q;
  assign m_axis_tlast_o  = out_row_end_q;
  assign m_axis_tuser_o  = out_lor_q;

  a_phase_two_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s1_valid_q && s1_last_q && !s1_seen0_q))
    else $error("second-pixel phase without a two-pixel word");

  a_row_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_row_end_q) |-> out_lor_q)
    else $error("row end pixel not last of its run");

  a_seen_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("column count beyond saturation");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast_i) |=> (seen_q == 2'd0 && !parity_q))
    else $error("row state not cleared after last column");

endmodule

// File: test/bayer_demosaic_3x3_bilinear_top_tb.sv
`timescale 1ns / 100ps

module bayer_demosaic_3x3_bilinear_top_tb;
  import bdm_pkg::*;

  typedef struct {
    rgb_t rgb;
    logic row_end;
    logic run_end;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;  // top_pixel, middle_pixel, bottom_pixel
  logic [1:0]  s_axis_tuser_i = '0;  // mode
  logic        s_axis_tlast_i = 1'b0; // last_in_row
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // red, green, blue
  logic        m_axis_tuser_o;       // last_of_run
  logic        m_axis_tlast_o;       // row_end

  bayer_demosaic_3x3_bilinear_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // column history kept alongside the block
  col_t       older_col;
  col_t       prev_col;
  logic [1:0] cols_in_row;
  logic       pix_parity;

  pixel_t pending_pixels[$];
  int     error_count;
  int     columns_sent;
  logic   calm;

  function automatic logic pause_now();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  function automatic rgb_t interpolate_rgb(col_t lc, col_t cc, col_t rc, logic parity,
                                           logic [1:0] mode);
    logic       green_site;
    logic       red_row;
    logic [9:0] horiz, vert, diag, plus;
    rgb_t       px;
    green_site = (parity ^ mode[1]) == 1'b0;
    red_row    = mode[0];
    horiz = (10'(lc.middle) + 10'(rc.middle)) >> 1;
    vert  = (10'(cc.top) + 10'(cc.bottom)) >> 1;
    diag  = (10'(lc.top) + 10'(rc.top) + 10'(lc.bottom) + 10'(rc.bottom)) >> 2;
    plus  = (10'(cc.top) + 10'(lc.middle) + 10'(rc.middle) + 10'(cc.bottom)) >> 2;
    if (green_site) begin
      px.green = cc.middle;
      px.red   = red_row ? horiz[7:0] : vert[7:0];
      px.blue  = red_row ? vert[7:0] : horiz[7:0];
    end else begin
      px.green = plus[7:0];
      px.red   = red_row ? cc.middle : diag[7:0];
      px.blue  = red_row ? diag[7:0] : cc.middle;
    end
    return px;
  endfunction

  function automatic void predict_pixels(col_t cur, logic [1:0] mode, logic last);
    pixel_t px;
    if (cols_in_row == 2'd0) begin
      // a one-column row folds onto itself
      if (last) begin
        px.rgb     = interpolate_rgb(cur, cur, cur, 1'b0, mode);
        px.row_end = 1'b1;
        px.run_end = 1'b1;
        pending_pixels.push_back(px);
      end
    end else begin
      px.rgb     = interpolate_rgb((cols_in_row == 2'd1) ? cur : older_col, prev_col, cur,
                                   pix_parity, mode);
      px.row_end = 1'b0;
      px.run_end = !last;
      pending_pixels.push_back(px);
      pix_parity = !pix_parity;
      if (last) begin
        px.rgb     = interpolate_rgb(prev_col, cur, prev_col, pix_parity, mode);
        px.row_end = 1'b1;
        px.run_end = 1'b1;
        pending_pixels.push_back(px);
      end
    end
    older_col = prev_col;
    prev_col  = cur;
    if (last) begin
      cols_in_row = 2'd0;
      pix_parity  = 1'b0;
    end else if (cols_in_row < 2'd2) begin
      cols_in_row = cols_in_row + 2'd1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_column(logic [7:0] top, logic [7:0] middle, logic [7:0] bottom,
                             logic [1:0] mode, logic last);
    col_t c;
    while (pause_now()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    c.top    = top;
    c.middle = middle;
    c.bottom = bottom;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= mode;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_pixels(c, mode, last);
    columns_sent++;
  endtask

  function automatic logic [7:0] random_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_single_column();
    send_column(8'hFF, 8'hFF, 8'hFF, 2'd0, 1'b1);
    send_column(8'h00, 8'h00, 8'h00, 2'd3, 1'b1);
  endtask

  task automatic test_each_mode();
    for (int m = 0; m < 4; m++) begin
      send_column(8'hFE, 8'h01, 8'hFF, 2'(m), 1'b0);
      send_column(8'h7F, 8'hFF, 8'h80, 2'(m), 1'b1);
    end
    // all-ones row: largest four-sample sums
    for (int i = 0; i < 4; i++) send_column(8'hFF, 8'hFF, 8'hFF, 2'd2, i == 3);
  endtask

  task automatic test_odd_row_mode_change();
    send_column(8'h10, 8'hA5, 8'h5A, 2'd0, 1'b0);
    send_column(8'hC3, 8'h3C, 8'h00, 2'd1, 1'b0);
    send_column(8'hFF, 8'h81, 8'h42, 2'd2, 1'b1);
  endtask

  task automatic test_random_rows();
    int         width;
    int         kind;
    logic       mixed;
    logic [1:0] mode;
    while (columns_sent < 900) begin
      kind  = $urandom_range(0, 99);
      mixed = 1'b0;
      if (kind < 80) width = 2 * $urandom_range(1, 6);
      else if (kind < 88) width = 2 * $urandom_range(1, 5) + 1;
      else if (kind < 94) width = 1;
      else begin
        width = $urandom_range(2, 9);
        mixed = 1'b1;
      end
      mode = 2'($urandom_range(0, 3));
      for (int i = 0; i < width; i++) begin
        calm = (columns_sent >= 300) && (columns_sent < 460);
        if (mixed) mode = 2'($urandom_range(0, 3));
        send_column(random_sample(), random_sample(), random_sample(), mode, i == width - 1);
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) m_axis_tready_i <= !pause_now();

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    rgb_t   got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %h with none expected", m_axis_tdata_o));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.rgb.red)
          report_mismatch($sformatf("red %h, expected %h", got.red, want.rgb.red));
        if (got.green !== want.rgb.green)
          report_mismatch($sformatf("green %h, expected %h", got.green, want.rgb.green));
        if (got.blue !== want.rgb.blue)
          report_mismatch($sformatf("blue %h, expected %h", got.blue, want.rgb.blue));
        if (m_axis_tlast_o !== want.row_end)
          report_mismatch($sformatf("row_end %b, expected %b", m_axis_tlast_o, want.row_end));
        if (m_axis_tuser_o !== want.run_end)
          report_mismatch($sformatf("last_of_run %b, expected %b", m_axis_tuser_o,
                                    want.run_end));
      end
    end
  end

  initial begin
    older_col    = '0;
    prev_col     = '0;
    cols_in_row  = 2'd0;
    pix_parity   = 1'b0;
    error_count  = 0;
    columns_sent = 0;
    calm         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_column();
    test_each_mode();
    test_odd_row_mode_change();
    test_random_rows();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    // catch any stray word after the last expected one
    repeat (10) @(posedge clk_i);
    if (pending_pixels.size() == 0 && error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
